// ===== rtl/sha256_pkg.sv =====
package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 61;
  localparam int unsigned LenW   = 64;

  typedef logic [WordW-1:0] word_t;
  // Working variables and hash words: index 0 is a (H0), index 7 is h (H7).
  typedef logic [7:0][WordW-1:0] vars_t;
  // Message schedule window: index 15 holds the oldest word W[t].
  typedef logic [15:0][WordW-1:0] sched_t;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [7:0]        PadByte  = 8'h80;
  localparam logic [5:0]        LenPos   = 6'd56;

  localparam vars_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/sha256_if.sv =====
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       is_last;

  modport source (output valid, output message_byte, output byte_present, output is_last,
                  input ready);
  modport sink (input valid, input message_byte, input byte_present, input is_last,
                output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        status;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  output status, input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                input status, output ready);
endinterface

// ===== rtl/sha256_round.sv =====
module sha256_round import sha256_pkg::*; (
  input  vars_t  vars_i,
  input  sched_t win_i,
  input  word_t  k_i,
  output vars_t  vars_o,
  output word_t  w_new_o
);

  word_t a, b, c, d, e, f, g, h;
  word_t wt, w1, w9, w14;
  word_t sig0, sig1, bsig0, bsig1, ch, maj, t1, t2;

  always_comb begin
    a = vars_i[0]; b = vars_i[1]; c = vars_i[2]; d = vars_i[3];
    e = vars_i[4]; f = vars_i[5]; g = vars_i[6]; h = vars_i[7];
    wt  = win_i[15];
    w1  = win_i[14];
    w9  = win_i[6];
    w14 = win_i[1];

    // The window always extends by one word, so it holds W[t+1..t+16] next round.
    sig0    = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
    sig1    = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
    w_new_o = wt + sig0 + w9 + sig1;

    bsig1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
    bsig0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
    ch    = (e & f) ^ (~e & g);
    maj   = (a & b) ^ (a & c) ^ (b & c);
    t1    = h + bsig1 + ch + k_i + wt;
    t2    = bsig0 + maj;

    vars_o[0] = t1 + t2;
    vars_o[1] = a;
    vars_o[2] = b;
    vars_o[3] = c;
    vars_o[4] = d + t1;
    vars_o[5] = e;
    vars_o[6] = f;
    vars_o[7] = g;
  end

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// Channel  Direction  Transaction carries
// in_i     sink       message_byte, byte_present, is_last
// out_o    source     digest_word, word_index, last_word, status
//
// A message byte is taken while in_i is ready; every 64th starts a compression
// (load, 64 rounds through the single round unit, hash update) before in_i is
// ready again. Unless overflowed, a last item adds up to 72 padding bytes, one
// per cycle, one compression per padding block, then eight output transactions.
// Reset is asynchronous, active low, and loads the initial hash values.
// A stalled output holds its word; no input is taken until all eight are sent.
module sha256_stream_hasher import sha256_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  sha256_in_if.sink   in_i,
  sha256_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROUND, S_FINAL, S_PAD, S_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [5:0]          pos_q, pos_d;
  logic [5:0]          t_q, t_d;
  logic [2:0]          idx_q, idx_d;
  logic                last_pend_q, last_pend_d;
  logic                sent80_q, sent80_d;
  logic                len_blk_q, len_blk_d;
  logic                fin_blk_q, fin_blk_d;
  logic [LenW-1:0]     len_q, len_d;
  vars_t               hash_q, hash_d;
  vars_t               vars_q, vars_d;
  logic [511:0]        win_q, win_d;

  vars_t               round_vars;
  word_t               new_w;
  logic                in_fire, out_fire, push, count_full;
  logic [7:0]          push_byte;

  sha256_round u_round (
    .vars_i  (vars_q),
    .win_i   (win_q),
    .k_i     (round_k(t_q)),
    .vars_o  (round_vars),
    .w_new_o (new_w)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign count_full = (count_q == CountMax);

  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = ovf_q ? '0 : hash_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);
  assign out_o.status      = ovf_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    t_d         = t_q;
    idx_d       = idx_q;
    last_pend_d = last_pend_q;
    sent80_d    = sent80_q;
    len_blk_d   = len_blk_q;
    fin_blk_d   = fin_blk_q;
    len_d       = len_q;
    hash_d      = hash_q;
    vars_d      = vars_q;
    win_d       = win_q;
    push        = 1'b0;
    push_byte   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.byte_present) begin
            if (count_full) begin
              ovf_d = 1'b1;
            end else begin
              push      = 1'b1;
              push_byte = in_i.message_byte;
              count_d   = count_q + 1'b1;
            end
          end
          if (push && (pos_q == 6'd63)) begin
            last_pend_d = in_i.is_last;
            state_d     = S_LOAD;
          end else if (in_i.is_last) begin
            state_d = ovf_d ? S_OUT : S_PAD;
          end
        end
      end
      S_LOAD: begin
        vars_d  = hash_q;
        t_d     = '0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        vars_d = round_vars;
        win_d  = {win_q[479:0], new_w};
        t_d    = t_q + 1'b1;
        if (t_q == 6'd63) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        for (int j = 0; j < 8; j++) begin
          hash_d[j] = hash_q[j] + vars_q[j];
        end
        if (fin_blk_q) begin
          state_d = S_OUT;
        end else if (last_pend_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PAD: begin
        push        = 1'b1;
        last_pend_d = 1'b1;
        if (!sent80_q) begin
          push_byte = PadByte;
          sent80_d  = 1'b1;
          len_blk_d = (pos_q < LenPos);
          len_d     = {count_q, 3'b000};
        end else if (len_blk_q && (pos_q >= LenPos)) begin
          push_byte = len_q[LenW-1 -: 8];
          len_d     = {len_q[LenW-9:0], 8'h00};
        end
        if (pos_q == 6'd63) begin
          state_d = S_LOAD;
          // The length goes into the block after the one that took the pad byte late.
          if (len_blk_q && sent80_q) begin
            fin_blk_d = 1'b1;
          end else begin
            len_blk_d = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_fire) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 3'd7) begin
            hash_d      = InitHash;
            count_d     = '0;
            ovf_d       = 1'b0;
            pos_d       = '0;
            last_pend_d = 1'b0;
            sent80_d    = 1'b0;
            len_blk_d   = 1'b0;
            fin_blk_d   = 1'b0;
            state_d     = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (push) begin
      win_d = {win_q[503:0], push_byte};
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
      t_q         <= '0;
      idx_q       <= '0;
      last_pend_q <= 1'b0;
      sent80_q    <= 1'b0;
      len_blk_q   <= 1'b0;
      fin_blk_q   <= 1'b0;
      hash_q      <= InitHash;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      pos_q       <= pos_d;
      t_q         <= t_d;
      idx_q       <= idx_d;
      last_pend_q <= last_pend_d;
      sent80_q    <= sent80_d;
      len_blk_q   <= len_blk_d;
      fin_blk_q   <= fin_blk_d;
      hash_q      <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    win_q  <= win_d;
    len_q  <= len_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a digest is being sent");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_word) |=> (in_i.ready && (pos_q == 6'd0)))
    else $error("block did not restart after the final digest word");

  a_rounds_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && t_q == 6'd63) |=> (state_q == S_FINAL))
    else $error("compression did not end after 64 rounds");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status) |-> (out_o.digest_word == 32'd0))
    else $error("overflowed message reported a nonzero digest word");

endmodule

// ===== tb/sha256_stream_hasher_test.sv =====
module sha256_stream_hasher_test;
  import sha256_pkg::*;

  localparam logic [7:0][31:0] HashSeed = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [60:0] CountLimit = '1;
  localparam logic [7:0]  PadMark    = 8'h80;
  localparam int          LenOffset  = 56;
  localparam int          RandomItems = 170;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       hold;
    logic [6:0] src_idle;
    logic [6:0] snk_stall;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
    logic        status;
  } digest_word_t;

  logic clk_i;
  logic rst_ni;

  sha256_in_if  in_if ();
  sha256_out_if out_if ();

  sha256_stream_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  msg_item_t    msg_q [$];
  digest_word_t digest_q [$];

  logic [7:0][31:0] run_hash;
  logic [63:0][7:0] run_block;
  logic [60:0]      run_count;
  logic             run_overflow;

  msg_item_t   next_item;
  logic        in_taken;
  logic [6:0]  snk_stall;
  int          mismatch_cnt;

  // Settings of the item being generated.
  logic [6:0]  gen_src_idle;
  logic [6:0]  gen_snk_stall;
  logic        gen_hold;
  int          random_cnt;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [7:0][31:0] sha_compress(input logic [7:0][31:0] h_in,
                                                    input logic [63:0][7:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    logic [7:0][31:0] h_out;
    int t;
    for (t = 0; t < 16; t++) begin
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    end
    for (t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {a, b, c, d} = {h_in[0], h_in[1], h_in[2], h_in[3]};
    {e, f, g, h} = {h_in[4], h_in[5], h_in[6], h_in[7]};
    for (t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
           RoundConst[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    h_out[0] = h_in[0] + a; h_out[1] = h_in[1] + b;
    h_out[2] = h_in[2] + c; h_out[3] = h_in[3] + d;
    h_out[4] = h_in[4] + e; h_out[5] = h_in[5] + f;
    h_out[6] = h_in[6] + g; h_out[7] = h_in[7] + h;
    return h_out;
  endfunction

  task automatic hash_absorb(input msg_item_t it);
    logic [5:0]   fill;
    logic [63:0]  bit_len;
    digest_word_t dw;
    int           i;
    if (it.present) begin
      // A byte past the largest countable length is dropped and flagged.
      if (run_count == CountLimit) begin
        run_overflow = 1'b1;
      end else begin
        run_block[run_count[5:0]] = it.data;
        run_count = run_count + 1'b1;
        if (run_count[5:0] == 6'd0) begin
          run_hash = sha_compress(run_hash, run_block);
        end
      end
    end
    if (it.last) begin
      if (!run_overflow) begin
        fill = run_count[5:0];
        bit_len = {run_count, 3'b000};
        run_block[fill] = PadMark;
        for (i = 0; i < 64; i++) begin
          if (i > fill) begin
            run_block[i] = 8'h00;
          end
        end
        // No room left for the length field, so it goes into an extra block.
        if (fill >= LenOffset) begin
          run_hash = sha_compress(run_hash, run_block);
          run_block = '0;
        end
        for (i = 0; i < 8; i++) begin
          run_block[LenOffset + i] = bit_len[63 - 8*i -: 8];
        end
        run_hash = sha_compress(run_hash, run_block);
      end
      for (i = 0; i < 8; i++) begin
        dw.word   = run_overflow ? 32'h0 : run_hash[i];
        dw.index  = 3'(i);
        dw.last   = (i == 7);
        dw.status = run_overflow;
        digest_q.push_back(dw);
      end
      run_hash = HashSeed;
      run_count = '0;
      run_overflow = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic queue_item(input logic [7:0] data, input logic present, input logic last);
    msg_item_t it;
    it.data = data;
    it.present = present;
    it.last = last;
    it.hold = gen_hold;
    it.src_idle = gen_src_idle;
    it.snk_stall = gen_snk_stall;
    gen_hold = 1'b0;
    if (present || last) begin
      random_cnt++;
    end
    msg_q.push_back(it);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Driver: a new transaction is offered at the falling edge once the previous
  // one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (msg_q.size() > 0 && !(msg_q[0].hold && digest_q.size() > 0) &&
          $urandom_range(0, 99) >= msg_q[0].src_idle) begin
        next_item = msg_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.message_byte <= next_item.data;
        in_if.byte_present <= next_item.present;
        in_if.is_last <= next_item.last;
        snk_stall <= next_item.snk_stall;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= ($urandom_range(0, 99) >= snk_stall);
  end

  // Monitor: prediction on each accepted input, checking on each accepted output.
  always @(posedge clk_i) begin
    digest_word_t want;
    msg_item_t    seen;
    in_taken <= in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready) begin
      seen = '0;
      seen.data = in_if.message_byte;
      seen.present = in_if.byte_present;
      seen.last = in_if.is_last;
      hash_absorb(seen);
    end
    if (out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", out_if.digest_word, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (out_if.digest_word !== want.word)
          report_mismatch("digest_word", out_if.digest_word, want.word);
        if (out_if.word_index !== want.index)
          report_mismatch("word_index", 32'(out_if.word_index), 32'(want.index));
        if (out_if.last_word !== want.last)
          report_mismatch("last_word", 32'(out_if.last_word), 32'(want.last));
        if (out_if.status !== want.status)
          report_mismatch("status", 32'(out_if.status), 32'(want.status));
      end
    end
  end

  initial begin
    int len;
    int i;
    int phase;
    int prev_phase;
    logic tail_byte;
    logic [6:0] phase_src [4];
    logic [6:0] phase_snk [4];
    int long_len [5];

    phase_src = '{7'd0, 7'd45, 7'd0, 7'd31};
    phase_snk = '{7'd0, 7'd0, 7'd45, 7'd31};
    long_len = '{55, 56, 63, 64, 65};

    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.message_byte = 8'h00;
    in_if.byte_present = 1'b0;
    in_if.is_last = 1'b0;
    out_if.ready = 1'b0;
    in_taken = 1'b0;
    snk_stall = '0;
    mismatch_cnt = 0;
    run_hash = HashSeed;
    run_block = '0;
    run_count = '0;
    run_overflow = 1'b0;
    gen_src_idle = '0;
    gen_snk_stall = '0;
    gen_hold = 1'b0;
    random_cnt = 0;

    // Directed: empty message, ignored empty items, single extreme bytes, short text.
    queue_item(8'h00, 1'b0, 1'b1);
    queue_item(8'hff, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b1);
    queue_item(8'hff, 1'b1, 1'b1);
    queue_item(8'h61, 1'b1, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1);
    queue_item(8'h00, 1'b1, 1'b0);
    queue_item(8'h5a, 1'b0, 1'b0);
    queue_item(8'hff, 1'b1, 1'b0);
    queue_item(8'ha5, 1'b0, 1'b1);
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'hff, 1'b0, 1'b1);

    // Random messages; the length overflow needs 2^61 bytes and is out of reach.
    random_cnt = 0;
    prev_phase = -1;
    while (random_cnt < RandomItems) begin
      phase = (random_cnt / 40) % 4;
      gen_src_idle = phase_src[phase];
      gen_snk_stall = phase_snk[phase];
      if (phase != prev_phase || $urandom_range(0, 7) == 0) begin
        gen_hold = 1'b1;
      end
      prev_phase = phase;
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(0, 15);
      end else begin
        len = long_len[$urandom_range(0, 4)];
      end
      tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          queue_item(8'($urandom), 1'b0, 1'b0);
        end
        queue_item(8'($urandom), 1'b1, tail_byte && (i == len - 1));
      end
      if (!tail_byte) begin
        queue_item(8'($urandom), 1'b0, 1'b1);
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (msg_q.size() == 0 && !in_if.valid);
    wait (digest_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatch_cnt == 0 && digest_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sha256_pkg.sv
rtl/sha256_if.sv
rtl/sha256_round.sv
rtl/sha256_stream_hasher.sv
tb/sha256_stream_hasher_test.sv
